/* rtl/jaur_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaur_pkg
// Shared types, register codes and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package jaur_pkg;

  localparam int PERIOD_W = 21;
  localparam int MASK_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 21'd2304;
  localparam logic [MASK_W-1:0]   MASK_RESET   = 6'd48;

  localparam logic signed [34:0] S32_MAX = 35'sd2147483647;
  localparam logic signed [34:0] S32_MIN = -35'sd2147483648;

  // classified item between front and back
  typedef struct packed {
    logic               rearm;
    logic               unwrap;
    logic [2:0]         joint;
    logic signed [23:0] raw;
    logic signed [15:0] cur;
  } sample_t;

  typedef struct packed {
    logic [2:0]         joint;
    logic signed [31:0] rel;
    logic signed [15:0] cur;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/jaur_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaur_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module jaur_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

/* rtl/jaur_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaur_front
// Accepts input items, drops bad joints, tags unwrap enable, feeds the queue.
// ----------------------------------------------------------------------------
module jaur_front #(
  parameter int NUM_JOINTS = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     mode,
  input  logic [2:0]               joint,
  input  logic signed [23:0]       raw_angle,
  input  logic signed [15:0]       motor_current,
  input  logic [jaur_pkg::MASK_W-1:0] mask,
  output logic                     q_push,
  output jaur_pkg::sample_t        q_data,
  input  logic                     q_full
);
  import jaur_pkg::*;

  sample_t    item;
  logic       item_valid;
  sample_t    cls;
  logic       keep;
  logic [2:0] jidx;
  logic [7:0] mask_ext;
  logic       take;

  assign jidx     = joint - 3'd1;
  assign mask_ext = 8'(mask);
  assign keep     = mode || ((joint != 3'd0) && (32'(joint) <= NUM_JOINTS));

  always_comb begin
    cls.rearm  = mode;
    cls.unwrap = (jidx < 3'(MASK_W)) && mask_ext[jidx];
    cls.joint  = joint;
    cls.raw    = raw_angle;
    cls.cur    = motor_current;
  end

  assign full   = item_valid && q_full;
  assign take   = push && !full;
  assign q_push = item_valid;
  assign q_data = item;

  always_ff @(posedge clk) begin
    if (take) begin
      item <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= keep;
    end else if (!q_full) begin
      item_valid <= 1'b0;
    end
  end

endmodule

/* rtl/jaur_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaur_back
// Two-stage execution: unwrap accumulator update, then zero capture and result.
// ----------------------------------------------------------------------------
module jaur_back #(
  parameter int NUM_JOINTS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [jaur_pkg::PERIOD_W-1:0] period,
  input  jaur_pkg::sample_t             q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          res_push,
  output jaur_pkg::result_t             res_data,
  input  logic                          res_full
);
  import jaur_pkg::*;

  localparam int IW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int XW = (IW > 3) ? IW : 3;

  // stage 1 state
  logic [NUM_JOINTS-1:0] started;
  logic signed [23:0]    prev_raw [NUM_JOINTS];
  logic signed [31:0]    acc      [NUM_JOINTS];
  // stage 2 state
  logic [NUM_JOINTS-1:0] needs_zero;
  logic signed [31:0]    zero_off [NUM_JOINTS];

  // stage 1
  logic [XW-1:0]      idx1_w;
  logic [IW-1:0]      idx1;
  logic signed [24:0] d;
  logic signed [25:0] d2;
  logic signed [25:0] per26;
  logic signed [32:0] per33;
  logic signed [32:0] acc33;
  logic signed [31:0] acc_next;
  logic signed [31:0] acc_use;
  logic               go1;

  // stage register
  logic               p_valid;
  sample_t            p;
  logic signed [31:0] p_acc;
  logic               go2;

  // stage 2
  logic [XW-1:0]      idx2_w;
  logic [IW-1:0]      idx2;
  logic signed [34:0] angle;
  logic signed [31:0] zcap;
  logic signed [31:0] zero_use;

  assign go2   = p_valid && !res_full;
  assign go1   = !q_empty && (!p_valid || go2);
  assign q_pop = go1;

  assign idx1_w = XW'(q_data.joint) - XW'(1);
  assign idx1   = idx1_w[IW-1:0];
  assign per26  = $signed({5'd0, period});
  assign per33  = $signed({12'd0, period});

  always_comb begin
    d  = 25'(q_data.raw) - 25'(prev_raw[idx1]);
    d2 = {d, 1'b0};
    priority if (d2 > per26) begin
      acc33 = 33'(acc[idx1]) - per33;
    end else if (d2 < -per26) begin
      acc33 = 33'(acc[idx1]) + per33;
    end else begin
      acc33 = 33'(acc[idx1]);
    end
    acc_next = sat32(35'(acc33));
    acc_use  = started[idx1] ? acc_next : acc[idx1];
  end

  always_ff @(posedge clk) begin
    if (go1 && !q_data.rearm && q_data.unwrap) begin
      prev_raw[idx1] <= q_data.raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= '0;
      for (int i = 0; i < NUM_JOINTS; i++) begin
        acc[i] <= '0;
      end
    end else if (go1) begin
      if (q_data.rearm) begin
        started <= '0;
        for (int i = 0; i < NUM_JOINTS; i++) begin
          acc[i] <= '0;
        end
      end else if (q_data.unwrap) begin
        started[idx1] <= 1'b1;
        acc[idx1]     <= acc_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      p     <= q_data;
      p_acc <= acc_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (go1) begin
      p_valid <= 1'b1;
    end else if (go2) begin
      p_valid <= 1'b0;
    end
  end

  // stage 2: angle, zero capture, relative angle
  assign idx2_w = XW'(p.joint) - XW'(1);
  assign idx2   = idx2_w[IW-1:0];

  always_comb begin
    angle    = p.unwrap ? (35'(p.raw) + 35'(p_acc)) : 35'(p.raw);
    zcap     = sat32(angle);
    zero_use = needs_zero[idx2] ? zcap : zero_off[idx2];
    res_data.joint = p.joint;
    res_data.rel   = sat32(angle - 35'(zero_use));
    res_data.cur   = p.cur;
  end

  assign res_push = go2 && !p.rearm;

  always_ff @(posedge clk) begin
    if (go2 && !p.rearm && needs_zero[idx2]) begin
      zero_off[idx2] <= zcap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needs_zero <= '1;
    end else if (go2) begin
      if (p.rearm) begin
        needs_zero <= '1;
      end else begin
        needs_zero[idx2] <= 1'b0;
      end
    end
  end

  a_rearm_started: assert property (@(posedge clk) disable iff (rst)
    go1 && q_data.rearm |=> started == '0)
    else $error("re-arm left a joint started");

  a_rearm_zero: assert property (@(posedge clk) disable iff (rst)
    go2 && p.rearm |=> needs_zero == '1)
    else $error("re-arm did not request new zeros");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    p_valid && res_full && !go1 |=> p_valid && $stable(p))
    else $error("stage register lost an item under stall");

endmodule

/* rtl/joint_angle_unwrap_rezero.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_angle_unwrap_rezero
// Per-joint angle unwrap with zero capture for a stream of joint samples.
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: drive the item on mode/joint/raw_angle/motor_current
//   and raise push; a transfer happens on a clock edge with push high and full
//   low. mode high is a re-arm event, which gives no result. samples whose
//   joint is 0 or above NUM_JOINTS are dropped without a result.
//   result side is a queue: while empty is low the oldest result sits on
//   out_joint/rel_angle/out_current, and a transfer happens on an edge with
//   pop high.
//   configuration writes use cfg_valid/cfg_ready (ready is always high):
//   index 0 is the unwrap period, index 1 the joint mask; write only while idle.
//   a result passes the front register, the classify queue, the stage
//   register and the result queue before it shows on the output.
//   throughput: one item per cycle while the receiver keeps up; the per-joint
//   state is read and written in the same cycle in each back stage, so samples
//   of the same joint can follow each other with no gap.
//   reset (synchronous, rst high) empties both queues, restores the register
//   defaults and marks every joint as needing a fresh zero.
//   a stalled receiver fills the result queue, then the stage register, then
//   the classify queue and the front register, and only then does full rise.
// ----------------------------------------------------------------------------
module joint_angle_unwrap_rezero #(
  parameter int NUM_JOINTS = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  // input queue side
  input  logic                            push,
  output logic                            full,
  input  logic                            mode,
  input  logic [2:0]                      joint,
  input  logic signed [23:0]              raw_angle,
  input  logic signed [15:0]              motor_current,
  // result queue side
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      out_joint,
  output logic signed [31:0]              rel_angle,
  output logic signed [15:0]              out_current,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jaur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jaur_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jaur_pkg::*;

  localparam int Q_DEPTH = 4;

  logic [PERIOD_W-1:0] period;
  logic [MASK_W-1:0]   mask;

  // front to classify queue
  logic    fq_push;
  sample_t fq_in;
  logic    fq_full;
  // classify queue to back
  sample_t bq_out;
  logic    bq_empty;
  logic    bq_pop;
  // back to result queue
  logic    rq_push;
  result_t rq_in;
  logic    rq_full;
  result_t rq_out;

  // configuration registers, writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
      mask   <= MASK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PERIOD: period <= cfg_data[PERIOD_W-1:0];
        REG_MASK:   mask   <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept, drop bad joints, tag unwrap enable
  jaur_front #(
    .NUM_JOINTS(NUM_JOINTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .mode          (mode),
    .joint         (joint),
    .raw_angle     (raw_angle),
    .motor_current (motor_current),
    .mask          (mask),
    .q_push        (fq_push),
    .q_data        (fq_in),
    .q_full        (fq_full)
  );

  // queue between front and back
  jaur_fifo #(
    .WIDTH($bits(sample_t)),
    .DEPTH(Q_DEPTH)
  ) u_cls_q (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_data (fq_in),
    .full      (fq_full),
    .pop       (bq_pop),
    .pop_data  (bq_out),
    .empty     (bq_empty)
  );

  // back: unwrap, zero capture, relative angle
  jaur_back #(
    .NUM_JOINTS(NUM_JOINTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .period   (period),
    .q_data   (bq_out),
    .q_empty  (bq_empty),
    .q_pop    (bq_pop),
    .res_push (rq_push),
    .res_data (rq_in),
    .res_full (rq_full)
  );

  // result queue, decouples the receiver from the back stages
  jaur_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(Q_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (rq_push),
    .push_data (rq_in),
    .full      (rq_full),
    .pop       (pop),
    .pop_data  (rq_out),
    .empty     (empty)
  );

  assign out_joint   = rq_out.joint;
  assign rel_angle   = rq_out.rel;
  assign out_current = rq_out.cur;

  // results only name real joints
  a_out_joint: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_joint != 3'd0) && (32'(out_joint) <= NUM_JOINTS))
    else $error("result carries an invalid joint");

endmodule
